/* src/fir_pkg.sv */
// Shared types, constants and helpers for the direct-form FIR filter.
package fir_pkg;

  localparam int MAX_TAPS_DEF    = 64;
  localparam int SAMPLE_BITS_DEF = 16;
  localparam int TAP_COUNT_W     = 7;
  localparam int COEF_INDEX_W    = 6;
  localparam int ACC_W           = 64;

  localparam logic [TAP_COUNT_W-1:0] TAP_COUNT_RST = TAP_COUNT_W'(1);

  localparam logic signed [ACC_W-1:0] ACC_MAX = {1'b0, {(ACC_W-1){1'b1}}};
  localparam logic signed [ACC_W-1:0] ACC_MIN = {1'b1, {(ACC_W-1){1'b0}}};

  typedef enum logic {
    OP_LOAD   = 1'b0,
    OP_FILTER = 1'b1
  } fir_op_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_MAC,
    ST_DRAIN,
    ST_FINISH
  } fir_state_e;

  typedef struct packed {
    logic start;   // take a sample word, set up a new sum
    logic load;    // take a coefficient word
    logic issue;   // read one tap pair into the MAC pipe
    logic finish;  // round the sum into the output register
  } fir_cmd_t;

  typedef struct packed {
    logic issue_done;
    logic pipe_empty;
    logic out_free;
  } fir_status_t;

  // Two's complement add that clips at the accumulator limits.
  function automatic logic signed [ACC_W-1:0] sat_add(input logic signed [ACC_W-1:0] a,
                                                      input logic signed [ACC_W-1:0] b);
    logic [ACC_W:0] s;
    s = {a[ACC_W-1], a} + {b[ACC_W-1], b};
    if (s[ACC_W] != s[ACC_W-1]) begin
      sat_add = s[ACC_W] ? ACC_MIN : ACC_MAX;
    end else begin
      sat_add = s[ACC_W-1:0];
    end
  endfunction

endpackage

/* src/fir_ctrl.sv */
// Sequencer for the FIR filter: accepts words and steps the shared MAC.
module fir_ctrl (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  input  logic                 op_i,
  output logic                 in_stall_o,
  input  fir_pkg::fir_status_t status_i,
  output fir_pkg::fir_cmd_t    cmd_o
);
  import fir_pkg::*;

  fir_state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i && (op_i == OP_FILTER)) state_d = ST_MAC;
      end
      ST_MAC: begin
        if (status_i.issue_done) state_d = ST_DRAIN;
      end
      ST_DRAIN: begin
        if (status_i.pipe_empty) state_d = ST_FINISH;
      end
      ST_FINISH: begin
        if (status_i.out_free) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd_o      = '0;
    in_stall_o = 1'b1;
    case (state_q)
      ST_IDLE: begin
        in_stall_o = 1'b0;
        if (in_valid_i) begin
          if (op_i == OP_FILTER) cmd_o.start = 1'b1;
          else                   cmd_o.load  = 1'b1;
        end
      end
      ST_MAC: begin
        cmd_o.issue = !status_i.issue_done;
      end
      ST_DRAIN: begin
        cmd_o = '0;
      end
      ST_FINISH: begin
        cmd_o.finish = status_i.out_free;
      end
      default: begin
        cmd_o = '0;
      end
    endcase
  end

endmodule

/* src/fir_dpath.sv */
// FIR datapath: tap and history memories, MAC pipe, rounding and output register.
module fir_dpath #(
  parameter int MAX_TAPS    = fir_pkg::MAX_TAPS_DEF,
  parameter int SAMPLE_BITS = fir_pkg::SAMPLE_BITS_DEF
) (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  cfg_we_i,
  input  logic [fir_pkg::TAP_COUNT_W-1:0]       cfg_wdata_i,
  input  logic [fir_pkg::COEF_INDEX_W-1:0]      coef_index_i,
  input  logic signed [SAMPLE_BITS-1:0]         coef_value_i,
  input  logic signed [SAMPLE_BITS-1:0]         sample_in_i,
  input  logic                                  first_of_signal_i,
  input  fir_pkg::fir_cmd_t                     cmd_i,
  output fir_pkg::fir_status_t                  status_o,
  output logic                                  out_valid_o,
  input  logic                                  out_stall_i,
  output logic signed [SAMPLE_BITS-1:0]         sample_out_o,
  output logic                                  saturated_o
);
  import fir_pkg::*;

  localparam int AW   = (MAX_TAPS > 1) ? $clog2(MAX_TAPS) : 1;
  localparam int CW   = $clog2(MAX_TAPS + 1);
  localparam int NW   = (CW > TAP_COUNT_W) ? CW : TAP_COUNT_W;
  localparam int FRAC = SAMPLE_BITS - 1;
  localparam int PW   = 2 * SAMPLE_BITS;

  localparam logic [AW-1:0] LAST_POS = AW'(MAX_TAPS - 1);
  localparam logic [CW-1:0] FILL_MAX = CW'(MAX_TAPS);

  localparam logic signed [ACC_W-1:0] HALF_LSB = ACC_W'(64'sd1 <<< (FRAC - 1));
  localparam logic signed [ACC_W-1:0] OUT_HI   = ACC_W'((64'sd1 <<< FRAC) - 64'sd1);
  localparam logic signed [ACC_W-1:0] OUT_LO   = -OUT_HI - ACC_W'(64'sd1);

  logic [TAP_COUNT_W-1:0]     tap_count_q;
  logic [CW-1:0]              fill_q, fill_d;
  logic [AW-1:0]              head_q, head_d;
  logic [CW-1:0]              n_q, n_d;
  logic [CW-1:0]              j_q;
  logic [AW-1:0]              pos_q;

  logic signed [SAMPLE_BITS-1:0] tap_mem  [MAX_TAPS];
  logic signed [SAMPLE_BITS-1:0] hist_mem [MAX_TAPS];
  logic signed [SAMPLE_BITS-1:0] tap_rd_q, hist_rd_q;
  logic                          rd_vld_q, prod_vld_q;
  logic signed [PW-1:0]          prod_q;
  logic signed [ACC_W-1:0]       acc_q;

  logic signed [ACC_W-1:0]       rnd;
  logic signed [ACC_W-1:0]       quo;
  logic signed [SAMPLE_BITS-1:0] res_d;
  logic                          sat_d;
  logic                          out_valid_q;
  logic signed [SAMPLE_BITS-1:0] sample_out_q;
  logic                          saturated_q;

  logic [NW-1:0] lim_a, lim_b;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tap_count_q <= TAP_COUNT_RST;
    end else if (cfg_we_i) begin
      tap_count_q <= cfg_wdata_i;
    end
  end

  // History bookkeeping for the incoming sample
  always_comb begin
    head_d = (head_q == LAST_POS) ? '0 : head_q + AW'(1);
    if (first_of_signal_i) fill_d = CW'(1);
    else if (fill_q == FILL_MAX) fill_d = fill_q;
    else fill_d = fill_q + CW'(1);
    // active taps: min(tap_count, MAX_TAPS, fill)
    lim_a = (NW'(tap_count_q) > NW'(FILL_MAX)) ? NW'(FILL_MAX) : NW'(tap_count_q);
    lim_b = (lim_a > NW'(fill_d)) ? NW'(fill_d) : lim_a;
    n_d   = CW'(lim_b);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fill_q <= '0;
      head_q <= '0;
    end else if (cmd_i.start) begin
      fill_q <= fill_d;
      head_q <= head_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      n_q <= '0;
      j_q <= '0;
    end else if (cmd_i.start) begin
      n_q <= n_d;
      j_q <= '0;
    end else if (cmd_i.issue) begin
      j_q <= j_q + CW'(1);
    end
  end

  // Walk back through the history ring, newest sample first
  always_ff @(posedge clk_i) begin
    if (cmd_i.start) begin
      pos_q <= head_d;
    end else if (cmd_i.issue) begin
      pos_q <= (pos_q == '0) ? LAST_POS : pos_q - AW'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load && (32'(coef_index_i) < 32'(MAX_TAPS))) begin
      tap_mem[AW'(coef_index_i)] <= coef_value_i;
    end
    if (cmd_i.issue) begin
      tap_rd_q <= tap_mem[j_q[AW-1:0]];
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.start) begin
      hist_mem[head_d] <= sample_in_i;
    end
    if (cmd_i.issue) begin
      hist_rd_q <= hist_mem[pos_q];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rd_vld_q   <= 1'b0;
      prod_vld_q <= 1'b0;
    end else begin
      rd_vld_q   <= cmd_i.issue;
      prod_vld_q <= rd_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_vld_q) begin
      prod_q <= PW'(tap_rd_q) * PW'(hist_rd_q);
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.start) begin
      acc_q <= '0;
    end else if (prod_vld_q) begin
      acc_q <= sat_add(acc_q, ACC_W'(prod_q));
    end
  end

  // Round half up, then clip to the output range
  always_comb begin
    rnd = sat_add(acc_q, HALF_LSB);
    quo = rnd >>> FRAC;
    if (quo > OUT_HI) begin
      res_d = OUT_HI[SAMPLE_BITS-1:0];
      sat_d = 1'b1;
    end else if (quo < OUT_LO) begin
      res_d = OUT_LO[SAMPLE_BITS-1:0];
      sat_d = 1'b1;
    end else begin
      res_d = quo[SAMPLE_BITS-1:0];
      sat_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.finish) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.finish) begin
      sample_out_q <= res_d;
      saturated_q  <= sat_d;
    end
  end

  assign status_o.issue_done = (j_q == n_q);
  assign status_o.pipe_empty = !rd_vld_q && !prod_vld_q;
  assign status_o.out_free   = !out_valid_q || !out_stall_i;

  assign out_valid_o  = out_valid_q;
  assign sample_out_o = sample_out_q;
  assign saturated_o  = saturated_q;

endmodule

/* src/fir_filter_direct_form.sv */
// Direct-form FIR filter top level: one shared multiply-accumulate over the taps.
// Flow: an accepted sample word enters the history ring, the MAC steps over n taps, the pipe
//   drains, and the rounded sum is registered once the output is free; n = min(tap_count,
//   MAX_TAPS, samples since the first of the signal). The single MAC steps one tap a cycle.
// A sample word stalls the input until its result is registered, so an output stall holds it
//   too; coefficient words are taken one per cycle. The output register holds a result while
//   the next word is accepted. Reset: tap_count returns to 1 and the history empties at once;
//   coefficients are undefined until loaded.
module fir_filter_direct_form #(
  parameter int MAX_TAPS    = fir_pkg::MAX_TAPS_DEF,
  parameter int SAMPLE_BITS = fir_pkg::SAMPLE_BITS_DEF
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             cfg_we_i,
  input  logic [fir_pkg::TAP_COUNT_W-1:0]  cfg_wdata_i,
  input  logic                             in_valid_i,
  output logic                             in_stall_o,
  input  logic                             op_i,
  input  logic [fir_pkg::COEF_INDEX_W-1:0] coef_index_i,
  input  logic signed [SAMPLE_BITS-1:0]    coef_value_i,
  input  logic signed [SAMPLE_BITS-1:0]    sample_in_i,
  input  logic                             first_of_signal_i,
  output logic                             out_valid_o,
  input  logic                             out_stall_i,
  output logic signed [SAMPLE_BITS-1:0]    sample_out_o,
  output logic                             saturated_o
);
  import fir_pkg::*;

  fir_cmd_t    cmd;
  fir_status_t status;

  fir_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .op_i       (op_i),
    .in_stall_o (in_stall_o),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  fir_dpath #(
    .MAX_TAPS    (MAX_TAPS),
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_dpath (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cfg_we_i          (cfg_we_i),
    .cfg_wdata_i       (cfg_wdata_i),
    .coef_index_i      (coef_index_i),
    .coef_value_i      (coef_value_i),
    .sample_in_i       (sample_in_i),
    .first_of_signal_i (first_of_signal_i),
    .cmd_i             (cmd),
    .status_o          (status),
    .out_valid_o       (out_valid_o),
    .out_stall_i       (out_stall_i),
    .sample_out_o      (sample_out_o),
    .saturated_o       (saturated_o)
  );

endmodule

/* src/fir_chk.sv */
// Port-level checks for the FIR filter, bound to the top level.
module fir_chk #(
  parameter int SAMPLE_BITS = fir_pkg::SAMPLE_BITS_DEF
) (
  input logic                             clk_i,
  input logic                             rst_ni,
  input logic                             in_valid_i,
  input logic                             in_stall_o,
  input logic                             op_i,
  input logic                             out_valid_o,
  input logic                             out_stall_i,
  input logic signed [SAMPLE_BITS-1:0]    sample_out_o,
  input logic                             saturated_o
);
  import fir_pkg::*;

  // Output word holds while stalled
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_stall_i) |=> (out_valid_o && $stable(sample_out_o)
                                      && $stable(saturated_o)))
    else $error("output word changed while stalled");

  // A sample word occupies the MAC, so the input stalls right after it
  a_sample_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o && (op_i == OP_FILTER)) |=> in_stall_o)
    else $error("input not stalled after a sample word");

  // Coefficient loads never stall the next word
  a_load_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o && (op_i == OP_LOAD)) |=> !in_stall_o)
    else $error("input stalled after a coefficient word");

  // A new result appears exactly as the filter returns to taking input
  a_result_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $fell(in_stall_o))
    else $error("result appeared outside the end of a sample");

endmodule

bind fir_filter_direct_form fir_chk #(.SAMPLE_BITS(SAMPLE_BITS)) u_fir_chk (.*);
